/* rtl/detector_hit_cluster_builder_defines.svh */
// Assertion macros shared by the cluster builder RTL.
// Need a clock, and for DHCB_ASSERT an active-low reset signal, passed in by the caller.
`ifndef DETECTOR_HIT_CLUSTER_BUILDER_DEFINES_SVH
`define DETECTOR_HIT_CLUSTER_BUILDER_DEFINES_SVH

// Check a property on every rising edge once reset is released.
`define DHCB_ASSERT(lbl, clk_s, rst_s, prop, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (!rst_s) prop) else $error(msg);

// Check a property on every rising edge, reset included.
`define DHCB_ASSERT_ALWAYS(lbl, clk_s, prop, msg) \
  lbl: assert property (@(posedge clk_s) prop) else $error(msg);

`endif

/* rtl/dhcb_pkg.sv */
// Shared types and constants of the detector hit cluster builder.
// No dependencies; imported by the top level.
package dhcb_pkg;

  localparam int ID_W     = 12;
  localparam int ENERGY_W = 24;
  localparam int TIME_W   = 20;
  localparam int CODE_W   = 16;
  localparam int APB_AW   = 4;
  localparam int APB_DW   = 32;

  localparam int DEF_MAX_CLUSTERS = 64;
  localparam int DEF_GROUP_SIZE   = 9;

  localparam logic signed [CODE_W-1:0] PARTICLE_GAMMA   = 16'sd22;
  localparam logic signed [CODE_W-1:0] PARTICLE_NEUTRON = 16'sd2112;

  localparam logic [ENERGY_W-1:0] ENERGY_MAX = '1;

  // command codes of the input channel
  localparam logic CMD_HIT = 1'b0;
  localparam logic CMD_EOE = 1'b1;

  // configuration register indexes
  localparam logic [1:0] REG_MODE       = 2'd0;
  localparam logic [1:0] REG_TIME_LIMIT = 2'd1;
  localparam logic [1:0] REG_ENERGY_THR = 2'd2;

  localparam logic [TIME_W-1:0]   RST_TIME_LIMIT = 20'd50000;
  localparam logic [ENERGY_W-1:0] RST_ENERGY_THR = 24'd5000;

  // one cluster table entry
  typedef struct packed {
    logic [ID_W-1:0]     key;
    logic [ENERGY_W-1:0] energy;
    logic [TIME_W-1:0]   tstamp;
  } entry_t;

endpackage

/* rtl/dhcb_ram.sv */
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies; used for the key map and the cluster table.
module dhcb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // write, and register the read word; hold it while no read is issued
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

/* rtl/detector_hit_cluster_builder.sv */
// Detector hit cluster builder: filter hits, merge them per key, emit on end of event.
// Hit: key build, key map read, table read-modify-write; in_ready stays low until done.
// Rejected hit: dropped on its transfer, the block stays idle. End of event: each result is
// read from the table and registered, the next one after out_ready (one table read per result).
// Reset (rst_n low, synchronous): table empty, overflow clear, registers at defaults; RAMs
// are not cleared, stale map entries are rejected by a key check.
`include "detector_hit_cluster_builder_defines.svh"

module detector_hit_cluster_builder
  import dhcb_pkg::*;
#(
  parameter int MAX_CLUSTERS = DEF_MAX_CLUSTERS,
  parameter int GROUP_SIZE   = DEF_GROUP_SIZE
) (
  input  logic                     clk,
  input  logic                     rst_n,
  // input channel
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic                     in_cmd,
  input  logic [ID_W-1:0]          in_det_id,
  input  logic [ENERGY_W-1:0]      in_hit_energy,
  input  logic [TIME_W-1:0]        in_hit_time,
  input  logic signed [CODE_W-1:0] in_particle_code,
  // result channel
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic [ID_W-1:0]          out_cluster_det,
  output logic [ENERGY_W-1:0]      out_energy_sum,
  output logic [TIME_W-1:0]        out_earliest_time,
  output logic                     out_entry_valid,
  output logic                     out_overflow,
  output logic                     out_last,
  // configuration port
  input  logic                     cfg_psel,
  input  logic                     cfg_penable,
  input  logic                     cfg_pwrite,
  input  logic [APB_AW-1:0]        cfg_paddr,
  input  logic [APB_DW-1:0]        cfg_pwdata,
  output logic [APB_DW-1:0]        cfg_prdata,
  output logic                     cfg_pready
);

  localparam int SLOT_W  = (MAX_CLUSTERS > 1) ? $clog2(MAX_CLUSTERS) : 1;
  localparam int CNT_W   = $clog2(MAX_CLUSTERS + 1);
  localparam int RECIP_W = ID_W + 1;
  localparam int PROD_W  = ID_W + RECIP_W;
  localparam int ENT_W   = ID_W + ENERGY_W + TIME_W;
  localparam int MAP_DEPTH = 1 << ID_W;

  // reciprocal of the group size, scaled by 2^ID_W; quotient is low by at most one
  localparam logic [RECIP_W-1:0] RECIP   = RECIP_W'((1 << ID_W) / GROUP_SIZE);
  localparam logic [ID_W-1:0]    GROUP_K = ID_W'(GROUP_SIZE);
  localparam logic [CNT_W-1:0]   CNT_MAX = CNT_W'(MAX_CLUSTERS);

  // state codes
  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_KEY   = 3'd1;
  localparam logic [2:0] ST_FIX   = 3'd2;
  localparam logic [2:0] ST_MAP   = 3'd3;
  localparam logic [2:0] ST_ENT   = 3'd4;
  localparam logic [2:0] ST_ERD   = 3'd5;
  localparam logic [2:0] ST_OWAIT = 3'd6;

  logic [2:0]          st_r, st_nxt;
  logic                cluster_mode_r;
  logic [TIME_W-1:0]   time_limit_r;
  logic [ENERGY_W-1:0] energy_threshold_r;
  logic [CNT_W-1:0]    count_r, count_nxt;
  logic                ovf_r, ovf_nxt;
  logic [SLOT_W-1:0]   idx_r, idx_nxt;

  logic [ID_W-1:0]     det_r, det_nxt;
  logic [ENERGY_W-1:0] energy_r, energy_nxt;
  logic [TIME_W-1:0]   time_r, time_nxt;
  logic [PROD_W-1:0]   prod_r, prod_nxt;
  logic [ID_W-1:0]     base_r, base_nxt;
  logic [ID_W-1:0]     key_r, key_nxt;

  logic                out_valid_r, out_valid_nxt;
  logic [ID_W-1:0]     out_det_r, out_det_nxt;
  logic [ENERGY_W-1:0] out_energy_r, out_energy_nxt;
  logic [TIME_W-1:0]   out_time_r, out_time_nxt;
  logic                out_ev_r, out_ev_nxt;
  logic                out_ovf_r, out_ovf_nxt;
  logic                out_last_r, out_last_nxt;

  // RAM ports
  logic                map_we, map_re;
  logic [ID_W-1:0]     map_waddr, map_raddr;
  logic [SLOT_W-1:0]   map_wdata, map_rdata;
  logic                ent_we, ent_re;
  logic [SLOT_W-1:0]   ent_waddr, ent_raddr;
  entry_t              ent_wdata, ent_rdata;

  logic                cfg_wr;
  logic                hit_pass;
  logic [RECIP_W-1:0]  quot;
  logic [ID_W-1:0]     rem;
  logic [ID_W-1:0]     grp_key;
  logic                found;
  logic [ENERGY_W:0]   sum_wide;
  logic [ENERGY_W-1:0] sum_sat;
  logic [TIME_W-1:0]   time_min;

  // key -> table slot map; entries hold garbage until written
  dhcb_ram #(
    .WIDTH (SLOT_W),
    .DEPTH (MAP_DEPTH)
  ) u_map_ram (
    .clk   (clk),
    .we    (map_we),
    .waddr (map_waddr),
    .wdata (map_wdata),
    .re    (map_re),
    .raddr (map_raddr),
    .rdata (map_rdata)
  );

  // cluster table in order of first appearance
  dhcb_ram #(
    .WIDTH (ENT_W),
    .DEPTH (MAX_CLUSTERS)
  ) u_ent_ram (
    .clk   (clk),
    .we    (ent_we),
    .waddr (ent_waddr),
    .wdata (ent_wdata),
    .re    (ent_re),
    .raddr (ent_raddr),
    .rdata (ent_rdata)
  );

  // configuration port
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_comb begin
    unique case (cfg_paddr[3:2])
      REG_MODE:       cfg_prdata = {{(APB_DW-1){1'b0}}, cluster_mode_r};
      REG_TIME_LIMIT: cfg_prdata = {{(APB_DW-TIME_W){1'b0}}, time_limit_r};
      REG_ENERGY_THR: cfg_prdata = {{(APB_DW-ENERGY_W){1'b0}}, energy_threshold_r};
      default:        cfg_prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cluster_mode_r     <= 1'b0;
      time_limit_r       <= RST_TIME_LIMIT;
      energy_threshold_r <= RST_ENERGY_THR;
    end else if (cfg_wr) begin
      unique case (cfg_paddr[3:2])
        REG_MODE:       cluster_mode_r     <= cfg_pwdata[0];
        REG_TIME_LIMIT: time_limit_r       <= cfg_pwdata[TIME_W-1:0];
        REG_ENERGY_THR: energy_threshold_r <= cfg_pwdata[ENERGY_W-1:0];
        default: ;
      endcase
    end
  end

  // hit filter on the incoming item
  assign hit_pass = ((in_particle_code == PARTICLE_GAMMA) ||
                     (in_particle_code == PARTICLE_NEUTRON)) &&
                    (in_hit_time <= time_limit_r) &&
                    (in_hit_energy >= energy_threshold_r);

  // group key correction: quotient estimate may be one low
  assign quot    = prod_r[PROD_W-1:ID_W];
  assign rem     = det_r - base_r;
  assign grp_key = (rem >= GROUP_K) ? (base_r + GROUP_K) : base_r;

  // merge arithmetic on the read entry
  assign found    = ({{(CNT_W-SLOT_W){1'b0}}, map_rdata} < count_r) &&
                    (ent_rdata.key == key_r);
  assign sum_wide = {1'b0, ent_rdata.energy} + {1'b0, energy_r};
  assign sum_sat  = sum_wide[ENERGY_W] ? ENERGY_MAX : sum_wide[ENERGY_W-1:0];
  assign time_min = (time_r < ent_rdata.tstamp) ? time_r : ent_rdata.tstamp;

  assign in_ready = (st_r == ST_IDLE);

  // sequencer: key build, map read, table read-modify-write, emit
  always_comb begin
    st_nxt         = st_r;
    count_nxt      = count_r;
    ovf_nxt        = ovf_r;
    idx_nxt        = idx_r;
    det_nxt        = det_r;
    energy_nxt     = energy_r;
    time_nxt       = time_r;
    prod_nxt       = prod_r;
    base_nxt       = base_r;
    key_nxt        = key_r;
    out_valid_nxt  = out_valid_r;
    out_det_nxt    = out_det_r;
    out_energy_nxt = out_energy_r;
    out_time_nxt   = out_time_r;
    out_ev_nxt     = out_ev_r;
    out_ovf_nxt    = out_ovf_r;
    out_last_nxt   = out_last_r;
    map_we         = 1'b0;
    map_re         = 1'b0;
    map_waddr      = key_r;
    map_raddr      = key_r;
    map_wdata      = count_r[SLOT_W-1:0];
    ent_we         = 1'b0;
    ent_re         = 1'b0;
    ent_waddr      = map_rdata;
    ent_raddr      = '0;
    ent_wdata      = '{key: key_r, energy: sum_sat, tstamp: time_min};

    unique case (st_r)
      ST_IDLE: begin
        if (in_valid) begin
          det_nxt    = in_det_id;
          energy_nxt = in_hit_energy;
          time_nxt   = in_hit_time;
          prod_nxt   = PROD_W'(in_det_id) * PROD_W'(RECIP);
          if (in_cmd == CMD_EOE) begin
            if (count_r == '0) begin
              // empty event: one marker result
              out_det_nxt    = '0;
              out_energy_nxt = '0;
              out_time_nxt   = '0;
              out_ev_nxt     = 1'b0;
              out_ovf_nxt    = ovf_r;
              out_last_nxt   = 1'b1;
              out_valid_nxt  = 1'b1;
              st_nxt         = ST_OWAIT;
            end else begin
              idx_nxt   = '0;
              ent_re    = 1'b1;
              ent_raddr = '0;
              st_nxt    = ST_ERD;
            end
          end else if (hit_pass) begin
            st_nxt = ST_KEY;
          end
        end
      end
      ST_KEY: begin
        base_nxt = ID_W'(quot * RECIP_W'(GROUP_SIZE));
        st_nxt   = ST_FIX;
      end
      ST_FIX: begin
        key_nxt   = cluster_mode_r ? grp_key : det_r;
        map_re    = 1'b1;
        map_raddr = key_nxt;
        st_nxt    = ST_MAP;
      end
      ST_MAP: begin
        ent_re    = 1'b1;
        ent_raddr = map_rdata;
        st_nxt    = ST_ENT;
      end
      ST_ENT: begin
        if (found) begin
          ent_we = 1'b1;
        end else if (count_r < CNT_MAX) begin
          // append a new cluster and point the map at it
          ent_we    = 1'b1;
          ent_waddr = count_r[SLOT_W-1:0];
          ent_wdata = '{key: key_r, energy: energy_r, tstamp: time_r};
          map_we    = 1'b1;
          count_nxt = count_r + CNT_W'(1);
        end else begin
          ovf_nxt = 1'b1;
        end
        st_nxt = ST_IDLE;
      end
      ST_ERD: begin
        out_det_nxt    = ent_rdata.key;
        out_energy_nxt = ent_rdata.energy;
        out_time_nxt   = ent_rdata.tstamp;
        out_ev_nxt     = 1'b1;
        out_ovf_nxt    = ovf_r;
        out_last_nxt   = ({{(CNT_W-SLOT_W){1'b0}}, idx_r} + CNT_W'(1)) == count_r;
        out_valid_nxt  = 1'b1;
        st_nxt         = ST_OWAIT;
      end
      ST_OWAIT: begin
        if (out_ready) begin
          out_valid_nxt = 1'b0;
          if (out_last_r) begin
            // event done: clear the table
            count_nxt = '0;
            ovf_nxt   = 1'b0;
            st_nxt    = ST_IDLE;
          end else begin
            idx_nxt   = idx_r + SLOT_W'(1);
            ent_re    = 1'b1;
            ent_raddr = idx_nxt;
            st_nxt    = ST_ERD;
          end
        end
      end
      default: st_nxt = ST_IDLE;
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= ST_IDLE;
      count_r     <= '0;
      ovf_r       <= 1'b0;
      out_valid_r <= 1'b0;
      idx_r       <= '0;
    end else begin
      st_r        <= st_nxt;
      count_r     <= count_nxt;
      ovf_r       <= ovf_nxt;
      out_valid_r <= out_valid_nxt;
      idx_r       <= idx_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    det_r        <= det_nxt;
    energy_r     <= energy_nxt;
    time_r       <= time_nxt;
    prod_r       <= prod_nxt;
    base_r       <= base_nxt;
    key_r        <= key_nxt;
    out_det_r    <= out_det_nxt;
    out_energy_r <= out_energy_nxt;
    out_time_r   <= out_time_nxt;
    out_ev_r     <= out_ev_nxt;
    out_ovf_r    <= out_ovf_nxt;
    out_last_r   <= out_last_nxt;
  end

  assign out_valid         = out_valid_r;
  assign out_cluster_det   = out_det_r;
  assign out_energy_sum    = out_energy_r;
  assign out_earliest_time = out_time_r;
  assign out_entry_valid   = out_ev_r;
  assign out_overflow      = out_ovf_r;
  assign out_last          = out_last_r;

  `DHCB_ASSERT(a_count_bound, clk, rst_n, count_r <= CNT_MAX, "cluster count above table size")
  `DHCB_ASSERT(a_no_overlap, clk, rst_n, !(in_ready && out_valid), "input taken while result pending")
  `DHCB_ASSERT_ALWAYS(a_reset_idle, clk, !rst_n |=> (in_ready && !out_valid), "block not idle after reset")
  `DHCB_ASSERT(a_clear_after_last, clk, rst_n, (out_valid && out_ready && out_last) |=> (count_r == '0 && !ovf_r), "table not cleared after last result")
  `DHCB_ASSERT(a_map_on_append, clk, rst_n, map_we |-> (ent_we && count_r < CNT_MAX), "map written without table append")

endmodule

/* tb/sv/tb.sv */
// Self-checking testbench of detector_hit_cluster_builder: hit filter, per-key merge,
// end-of-event emission, overflow and the register port, against a cluster table model.
// Depends on dhcb_pkg and the RTL of the block only.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import dhcb_pkg::*;

  localparam int        DRAIN_CYCLES = 12;
  localparam int        LONG_HOLD    = 400;
  localparam int        RANDOM_ITEMS = 325;
  localparam logic [1:0] REG_UNUSED  = 2'd3;

  typedef struct {
    logic [ID_W-1:0]     det;
    logic [ENERGY_W-1:0] energy;
    logic [TIME_W-1:0]   tstamp;
    logic                valid;
    logic                ovf;
    logic                last;
  } cluster_t;

  typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_e;

  typedef struct {
    row_kind_e                kind;
    logic                     cmd;
    logic [ID_W-1:0]          det;
    logic [ENERGY_W-1:0]      energy;
    logic [TIME_W-1:0]        tstamp;
    logic signed [CODE_W-1:0] code;
    logic [1:0]               reg_idx;
    logic [APB_DW-1:0]        reg_val;
    bit                       typed;
    cluster_t                 typed_result;
  } row_t;

  logic                     clk;
  logic                     rst_n            = 1'b0;
  logic                     in_valid         = 1'b0;
  logic                     in_ready;
  logic                     in_cmd           = CMD_HIT;
  logic [ID_W-1:0]          in_det_id        = '0;
  logic [ENERGY_W-1:0]      in_hit_energy    = '0;
  logic [TIME_W-1:0]        in_hit_time      = '0;
  logic signed [CODE_W-1:0] in_particle_code = '0;
  logic                     out_valid;
  logic                     out_ready        = 1'b0;
  logic [ID_W-1:0]          out_cluster_det;
  logic [ENERGY_W-1:0]      out_energy_sum;
  logic [TIME_W-1:0]        out_earliest_time;
  logic                     out_entry_valid;
  logic                     out_overflow;
  logic                     out_last;
  logic                     cfg_psel         = 1'b0;
  logic                     cfg_penable      = 1'b0;
  logic                     cfg_pwrite       = 1'b0;
  logic [APB_AW-1:0]        cfg_paddr        = '0;
  logic [APB_DW-1:0]        cfg_pwdata       = '0;
  logic [APB_DW-1:0]        cfg_prdata;
  logic                     cfg_pready;

  detector_hit_cluster_builder i_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_cmd            (in_cmd),
    .in_det_id         (in_det_id),
    .in_hit_energy     (in_hit_energy),
    .in_hit_time       (in_hit_time),
    .in_particle_code  (in_particle_code),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_cluster_det   (out_cluster_det),
    .out_energy_sum    (out_energy_sum),
    .out_earliest_time (out_earliest_time),
    .out_entry_valid   (out_entry_valid),
    .out_overflow      (out_overflow),
    .out_last          (out_last),
    .cfg_psel          (cfg_psel),
    .cfg_penable       (cfg_penable),
    .cfg_pwrite        (cfg_pwrite),
    .cfg_paddr         (cfg_paddr),
    .cfg_pwdata        (cfg_pwdata),
    .cfg_prdata        (cfg_prdata),
    .cfg_pready        (cfg_pready)
  );

  // cluster table model and its copy of the registers
  logic                cl_mode;
  logic [TIME_W-1:0]   cl_time_limit;
  logic [ENERGY_W-1:0] cl_energy_thr;
  logic [ID_W-1:0]     cl_key    [DEF_MAX_CLUSTERS];
  logic [ENERGY_W-1:0] cl_energy [DEF_MAX_CLUSTERS];
  logic [TIME_W-1:0]   cl_time   [DEF_MAX_CLUSTERS];
  int                  cl_count;
  logic                cl_ovf;

  cluster_t clusters_due[$];
  cluster_t no_result = '{default: 0};
  row_t     directed_rows[$];
  logic [ID_W-1:0] evt_dets[$];

  int  mismatches  = 0;
  int  items_sent  = 0;
  int  holds_asked = 0;
  int  holds_done  = 0;
  int  stall_left  = 0;
  bit  no_gaps     = 1'b0;
  cluster_t rx_exp;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("tb failed");
    $finish;
  end

  // Append one expected cluster at the tail of the result queue.
  function automatic void due_add(cluster_t c);
    clusters_due.insert(clusters_due.size(), c);
  endfunction

  // Append one row at the end of the directed table.
  function automatic void row_add(row_t r);
    directed_rows.insert(directed_rows.size(), r);
  endfunction

  // Merge one accepted item into the table model; queue the clusters an end of event emits.
  function automatic void cluster_predict(logic cmd, logic [ID_W-1:0] det,
                                          logic [ENERGY_W-1:0] energy,
                                          logic [TIME_W-1:0] tstamp,
                                          logic signed [CODE_W-1:0] code);
    logic [ID_W-1:0]   key;
    logic [ENERGY_W:0] sum;
    bit                found;
    int                k;
    found = 1'b0;
    if (cmd == CMD_HIT) begin
      if ((code == PARTICLE_GAMMA || code == PARTICLE_NEUTRON) &&
          tstamp <= cl_time_limit && energy >= cl_energy_thr) begin
        key = cl_mode ? ID_W'(DEF_GROUP_SIZE * (int'(det) / DEF_GROUP_SIZE)) : det;
        for (k = 0; k < cl_count; k++) begin
          if (!found && cl_key[k] == key) begin
            found = 1'b1;
            sum = {1'b0, cl_energy[k]} + {1'b0, energy};
            cl_energy[k] = sum[ENERGY_W] ? ENERGY_MAX : sum[ENERGY_W-1:0];
            if (tstamp < cl_time[k]) cl_time[k] = tstamp;
          end
        end
        if (!found) begin
          if (cl_count >= DEF_MAX_CLUSTERS) begin
            cl_ovf = 1'b1;
          end else begin
            cl_key[cl_count]    = key;
            cl_energy[cl_count] = energy;
            cl_time[cl_count]   = tstamp;
            cl_count++;
          end
        end
      end
    end else begin
      if (cl_count == 0) begin
        due_add('{'0, '0, '0, 1'b0, cl_ovf, 1'b1});
      end else begin
        for (k = 0; k < cl_count; k++)
          due_add('{cl_key[k], cl_energy[k], cl_time[k], 1'b1, cl_ovf, k == cl_count - 1});
      end
      cl_count = 0;
      cl_ovf   = 1'b0;
    end
  endfunction

  task automatic field_cmp(string name, longint exp_val, longint act_val);
    if (exp_val != act_val) begin
      mismatches++;
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, exp_val, act_val);
    end
  endtask

  // Receiver: check each result transfer, stall a random number of cycles after it.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
      stall_left = 0;
    end else begin
      if (out_valid && out_ready) begin
        if (clusters_due.size() == 0) begin
          mismatches++;
          $display("%0t: result with none expected, cluster_det %0d", $time, out_cluster_det);
        end else begin
          rx_exp = clusters_due.pop_front();
          field_cmp("cluster_det", longint'(rx_exp.det), longint'(out_cluster_det));
          field_cmp("energy_sum", longint'(rx_exp.energy), longint'(out_energy_sum));
          field_cmp("earliest_time", longint'(rx_exp.tstamp), longint'(out_earliest_time));
          field_cmp("entry_valid", longint'(rx_exp.valid), longint'(out_entry_valid));
          field_cmp("overflow", longint'(rx_exp.ovf), longint'(out_overflow));
          field_cmp("last", longint'(rx_exp.last), longint'(out_last));
        end
        stall_left = no_gaps ? 0 : $urandom_range(0, 11);
      end
      // long hold-off to back the block up into its input
      if (holds_done != holds_asked) begin
        holds_done++;
        stall_left = LONG_HOLD;
      end
      if (stall_left > 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Offer one item after a random gap, hold it until the transfer, then predict.
  task automatic send_item(logic cmd, logic [ID_W-1:0] det, logic [ENERGY_W-1:0] energy,
                           logic [TIME_W-1:0] tstamp, logic signed [CODE_W-1:0] code,
                           bit typed, cluster_t typed_result);
    int gap;
    gap = no_gaps ? 0 : $urandom_range(0, 11);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid         <= 1'b1;
    in_cmd           <= cmd;
    in_det_id        <= det;
    in_hit_energy    <= energy;
    in_hit_time      <= tstamp;
    in_particle_code <= code;
    do @(posedge clk); while (!in_ready);
    cluster_predict(cmd, det, energy, tstamp, code);
    if (typed) begin
      void'(clusters_due.pop_back());
      due_add(typed_result);
    end
    items_sent++;
  endtask

  // Write a register once the block has drained, then read it back.
  task automatic cfg_write(logic [1:0] idx, logic [APB_DW-1:0] value);
    logic [APB_DW-1:0] mask;
    logic [APB_DW-1:0] junk;
    in_valid <= 1'b0;
    while (clusters_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    case (idx)
      REG_MODE:       mask = 32'h1;
      REG_TIME_LIMIT: mask = 32'hF_FFFF;
      REG_ENERGY_THR: mask = 32'hFF_FFFF;
      default:        mask = '0;
    endcase
    junk = $urandom();
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {idx, 2'b00};
    cfg_pwdata  <= (value & mask) | (junk & ~mask);
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    if (mask != 0 && (cfg_prdata & mask) != (value & mask)) begin
      mismatches++;
      $display("%0t: register %0d readback, expected %0d, got %0d", $time, idx,
               value & mask, cfg_prdata & mask);
    end
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    case (idx)
      REG_MODE:       cl_mode       = value[0];
      REG_TIME_LIMIT: cl_time_limit = value[TIME_W-1:0];
      REG_ENERGY_THR: cl_energy_thr = value[ENERGY_W-1:0];
      default: ;
    endcase
  endtask

  function automatic void add_hit(logic [ID_W-1:0] det, logic [ENERGY_W-1:0] energy,
                                  logic [TIME_W-1:0] tstamp, logic signed [CODE_W-1:0] code);
    row_add('{ROW_ITEM, CMD_HIT, det, energy, tstamp, code, '0, '0, 1'b0, no_result});
  endfunction

  function automatic void add_eoe(bit typed, cluster_t typed_result);
    row_add('{ROW_ITEM, CMD_EOE, ID_W'($urandom()), ENERGY_W'($urandom()),
              TIME_W'($urandom()), CODE_W'($urandom()), '0, '0, typed, typed_result});
  endfunction

  function automatic void add_cfg(logic [1:0] idx, logic [APB_DW-1:0] value);
    row_add('{ROW_CFG, CMD_HIT, '0, '0, '0, '0, idx, value, 1'b0, no_result});
  endfunction

  // Hit that passes the filter under the current settings.
  task automatic send_good_hit(logic [ID_W-1:0] det);
    logic [ENERGY_W-1:0]      energy;
    logic [TIME_W-1:0]        tstamp;
    logic signed [CODE_W-1:0] code;
    int unsigned              span;
    span = 32'(ENERGY_MAX) - 32'(cl_energy_thr);
    case ($urandom_range(0, 3))
      0:       energy = cl_energy_thr;
      1:       energy = ENERGY_W'(32'(cl_energy_thr) +
                                  $urandom_range(0, (span > 2000) ? 2000 : span));
      default: energy = ENERGY_W'(32'(cl_energy_thr) + $urandom_range(0, span));
    endcase
    case ($urandom_range(0, 3))
      0:       tstamp = cl_time_limit;
      1:       tstamp = '0;
      default: tstamp = TIME_W'($urandom_range(0, 32'(cl_time_limit)));
    endcase
    code = $urandom_range(0, 1) ? PARTICLE_GAMMA : PARTICLE_NEUTRON;
    send_item(CMD_HIT, det, energy, tstamp, code, 1'b0, no_result);
  endtask

  // Hit with random or near-miss fields; most are dropped by the filter.
  task automatic send_noise_hit();
    logic signed [CODE_W-1:0] code;
    case ($urandom_range(0, 7))
      0: code = 16'sd21;
      1: code = 16'sd23;
      2: code = 16'sd2111;
      3: code = 16'sd2113;
      4: code = -16'sd22;
      5: code = $urandom_range(0, 1) ? PARTICLE_GAMMA : PARTICLE_NEUTRON;
      default: code = CODE_W'($urandom());
    endcase
    send_item(CMD_HIT, ID_W'($urandom()), ENERGY_W'($urandom()), TIME_W'($urandom()), code,
              1'b0, no_result);
  endtask

  task automatic send_eoe();
    send_item(CMD_EOE, ID_W'($urandom()), ENERGY_W'($urandom()), TIME_W'($urandom()),
              CODE_W'($urandom()), 1'b0, no_result);
  endtask

  // One event: hits on a few recurring keys plus noise, then end of event.
  task automatic run_event(int n_hits);
    int d;
    int h;
    evt_dets.delete();
    for (h = 0; h < n_hits; h++) begin
      if ($urandom_range(0, 4) == 0) begin
        send_noise_hit();
      end else begin
        if (evt_dets.size() != 0 && $urandom_range(0, 1)) begin
          d = int'(evt_dets[$urandom_range(0, evt_dets.size() - 1)]);
          if (cl_mode) begin
            d = d - d % DEF_GROUP_SIZE + $urandom_range(0, DEF_GROUP_SIZE - 1);
            if (d > 4095) d = 4095;
          end
        end else begin
          d = $urandom_range(0, 4095);
        end
        evt_dets.insert(evt_dets.size(), ID_W'(d));
        send_good_hit(ID_W'(d));
      end
    end
    send_eoe();
  endtask

  // More distinct keys than the table holds, then merges into keys already present.
  task automatic run_overflow_event();
    int n;
    int start;
    int step;
    int h;
    n     = DEF_MAX_CLUSTERS + $urandom_range(1, 6);
    start = $urandom_range(0, 4095);
    step  = cl_mode ? DEF_GROUP_SIZE : 1;
    for (h = 0; h < n; h++) send_good_hit(ID_W'((start + h * step) % 4096));
    send_good_hit(ID_W'(start));
    send_good_hit(ID_W'((start + step) % 4096));
    send_eoe();
  endtask

  task automatic random_settings();
    logic [TIME_W-1:0]   lim;
    logic [ENERGY_W-1:0] thr;
    case ($urandom_range(0, 3))
      0:       lim = '0;
      1:       lim = '1;
      2:       lim = RST_TIME_LIMIT;
      default: lim = TIME_W'($urandom());
    endcase
    case ($urandom_range(0, 3))
      0:       thr = '0;
      1:       thr = '1;
      2:       thr = RST_ENERGY_THR;
      default: thr = ENERGY_W'($urandom_range(0, 20000));
    endcase
    cfg_write(REG_MODE, $urandom_range(0, 1));
    cfg_write(REG_TIME_LIMIT, APB_DW'(lim));
    cfg_write(REG_ENERGY_THR, APB_DW'(thr));
    if ($urandom_range(0, 5) == 0) cfg_write(REG_UNUSED, $urandom());
  endtask

  initial begin
    int phase;
    cl_mode       = 1'b0;
    cl_time_limit = RST_TIME_LIMIT;
    cl_energy_thr = RST_ENERGY_THR;
    cl_count      = 0;
    cl_ovf        = 1'b0;

    // directed rows at reset settings: empty event, saturation, filter edges, min time
    add_eoe(1'b1, '{12'd0, 24'd0, 20'd0, 1'b0, 1'b0, 1'b1});
    add_hit(12'd4095, 24'hFF_FFFF, 20'd0, 16'sd22);
    add_hit(12'd4095, 24'd5000, 20'd50000, 16'sd2112);
    add_eoe(1'b1, '{12'd4095, 24'hFF_FFFF, 20'd0, 1'b1, 1'b0, 1'b1});
    add_hit(12'd100, 24'd5000, 20'd50000, 16'sd21);
    add_hit(12'd100, 24'd5000, 20'd50000, 16'sd2113);
    add_hit(12'd100, 24'd5000, 20'd50000, 16'sh8000);
    add_hit(12'd100, 24'd5000, 20'd50000, 16'sh7FFF);
    add_hit(12'd100, 24'd5000, 20'd50000, -16'sd22);
    add_hit(12'd100, 24'd4999, 20'd100, 16'sd22);
    add_hit(12'd100, 24'd6000, 20'd50001, 16'sd22);
    add_hit(12'd0, 24'd5000, 20'd50000, 16'sd22);
    add_eoe(1'b1, '{12'd0, 24'd5000, 20'd50000, 1'b1, 1'b0, 1'b1});
    add_hit(12'd5, 24'd8000, 20'd100, 16'sd2112);
    add_hit(12'd7, 24'd9000, 20'd30, 16'sd22);
    add_hit(12'd5, 24'd7000, 20'd20, 16'sd22);
    add_eoe(1'b0, no_result);
    // grouped mode: two pixels of the top group but one, and the lone top pixel
    add_cfg(REG_MODE, 32'd1);
    add_hit(12'd4094, 24'd6000, 20'd10, 16'sd22);
    add_hit(12'd4086, 24'd6000, 20'd5, 16'sd2112);
    add_hit(12'd4095, 24'd6000, 20'd0, 16'sd22);
    add_eoe(1'b0, no_result);
    // lowest limit and threshold
    add_cfg(REG_TIME_LIMIT, 32'd0);
    add_cfg(REG_ENERGY_THR, 32'd0);
    add_hit(12'd8, 24'd0, 20'd0, 16'sd22);
    add_hit(12'd9, 24'd0, 20'd1, 16'sd22);
    add_eoe(1'b1, '{12'd0, 24'd0, 20'd0, 1'b1, 1'b0, 1'b1});
    // highest limit and threshold, and a write to no register
    add_cfg(REG_TIME_LIMIT, 32'hF_FFFF);
    add_cfg(REG_ENERGY_THR, 32'hFF_FFFF);
    add_cfg(REG_UNUSED, 32'hFFFF_FFFF);
    add_hit(12'd4095, 24'hFF_FFFF, 20'hF_FFFF, 16'sd2112);
    add_hit(12'd1000, 24'hFF_FFFE, 20'd0, 16'sd22);
    add_eoe(1'b1, '{12'd4095, 24'hFF_FFFF, 20'hF_FFFF, 1'b1, 1'b0, 1'b1});
    add_cfg(REG_MODE, 32'd0);
    add_cfg(REG_TIME_LIMIT, APB_DW'(RST_TIME_LIMIT));
    add_cfg(REG_ENERGY_THR, APB_DW'(RST_ENERGY_THR));

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // walk the directed table
    foreach (directed_rows[r]) begin
      if (directed_rows[r].kind == ROW_CFG)
        cfg_write(directed_rows[r].reg_idx, directed_rows[r].reg_val);
      else
        send_item(directed_rows[r].cmd, directed_rows[r].det, directed_rows[r].energy,
                  directed_rows[r].tstamp, directed_rows[r].code, directed_rows[r].typed,
                  directed_rows[r].typed_result);
    end

    // random events under changing settings
    items_sent = 0;
    phase      = 0;
    while (items_sent < RANDOM_ITEMS) begin
      phase++;
      if (phase != 4 && (phase == 1 || $urandom_range(0, 2) == 0)) random_settings();
      no_gaps = (phase == 3) || ($urandom_range(0, 4) == 0);
      if (phase == 3) begin
        holds_asked++;
        run_event(24);
      end else if (phase == 5 || phase == 14) begin
        run_overflow_event();
      end else begin
        run_event($urandom_range(0, 12));
      end
    end

    // drain and finish
    in_valid <= 1'b0;
    while (clusters_due.size() != 0) @(posedge clk);
    repeat (2 * DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0)
      $display("tb passed");
    else
      $display("tb failed");
    $finish;
  end

endmodule
